[rtl/core/mwba_pkg.sv]
package mwba_pkg;

    localparam int unsigned DATA_W = 64;
    localparam int unsigned HALF_W = DATA_W / 2;

    localparam logic [3:0] OP_TRUNC   = 4'd0;
    localparam logic [3:0] OP_ADD     = 4'd1;
    localparam logic [3:0] OP_SUB     = 4'd2;
    localparam logic [3:0] OP_MUL     = 4'd3;
    localparam logic [3:0] OP_NOT     = 4'd4;
    localparam logic [3:0] OP_AND     = 4'd5;
    localparam logic [3:0] OP_OR      = 4'd6;
    localparam logic [3:0] OP_XOR     = 4'd7;
    localparam logic [3:0] OP_SHL     = 4'd8;
    localparam logic [3:0] OP_USHR    = 4'd9;
    localparam logic [3:0] OP_EXT_SL  = 4'd10;
    localparam logic [3:0] OP_EXT_HL  = 4'd11;
    localparam logic [3:0] OP_APPEND  = 4'd12;
    localparam logic [3:0] OP_SETW    = 4'd13;
    localparam logic [3:0] OP_SEXT    = 4'd14;
    localparam logic [3:0] OP_ALLONES = 4'd15;

    typedef logic [DATA_W-1:0] word_t;
    typedef logic [3:0]        op_t;
    typedef logic [6:0]        cnt_t;

    // decoded item: operands already cut to their widths
    typedef struct packed {
        op_t   op;
        word_t a;
        word_t b;
        word_t sext_bit;
        word_t res_mask;
        cnt_t  shift;
        logic  bad;
    } dec_t;

    // executed item: result for all ops but mul, plus the mul partial products
    typedef struct packed {
        op_t               op;
        word_t             pre;
        word_t             pp_low;
        logic [HALF_W-1:0] pp_mid_a;
        logic [HALF_W-1:0] pp_mid_b;
        word_t             res_mask;
        logic              bad;
    } exe_t;

    typedef struct packed {
        word_t result;
        logic  out_of_range;
    } res_t;

    function automatic word_t width_mask(input logic [7:0] w);
        word_t m;
        if (w >= 8'(DATA_W))
        begin
            m = '1;
        end
        else
        begin
            m = ~({DATA_W{1'b1}} << w[5:0]);
        end
        return m;
    endfunction

endpackage

[rtl/core/mwba_in_if.sv]
interface mwba_in_if;
    logic                valid;
    logic                ready;
    mwba_pkg::op_t       action;
    mwba_pkg::word_t     value_a;
    mwba_pkg::word_t     value_b;
    mwba_pkg::cnt_t      width_n;
    mwba_pkg::cnt_t      width_m;
    mwba_pkg::cnt_t      amount;
    mwba_pkg::cnt_t      high_index;

    modport source (
        output valid, action, value_a, value_b, width_n, width_m, amount, high_index,
        input  ready
    );

    modport sink (
        input  valid, action, value_a, value_b, width_n, width_m, amount, high_index,
        output ready
    );
endinterface

[rtl/core/mwba_out_if.sv]
interface mwba_out_if;
    logic            valid;
    logic            ready;
    mwba_pkg::word_t result;
    logic            out_of_range;

    modport source (
        output valid, result, out_of_range,
        input  ready
    );

    modport sink (
        input  valid, result, out_of_range,
        output ready
    );
endinterface

[rtl/core/mwba_decode.sv]
module mwba_decode #(
    parameter int unsigned MAX_WIDTH = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  mwba_pkg::op_t   action,
    input  mwba_pkg::word_t value_a,
    input  mwba_pkg::word_t value_b,
    input  mwba_pkg::cnt_t  width_n,
    input  mwba_pkg::cnt_t  width_m,
    input  mwba_pkg::cnt_t  amount,
    input  mwba_pkg::cnt_t  high_index,
    output logic            out_valid,
    output mwba_pkg::dec_t  out_data
);

    logic            valid_reg;
    mwba_pkg::dec_t  data_reg;
    mwba_pkg::dec_t  data_next;

    logic [7:0]      n8;
    logic [7:0]      m8;
    logic [7:0]      amt8;
    logic [7:0]      hi8;
    logic [7:0]      len8;
    logic [7:0]      lim;
    mwba_pkg::word_t mn;
    mwba_pkg::word_t mm;
    mwba_pkg::word_t ml;
    mwba_pkg::word_t mask;
    logic            n_bad;
    logic            m_bad;
    logic            bad;

    always_comb
    begin
        n8    = {1'b0, width_n};
        m8    = {1'b0, width_m};
        amt8  = {1'b0, amount};
        hi8   = {1'b0, high_index};
        len8  = hi8 - amt8 + 8'd1;
        lim   = 8'(MAX_WIDTH);
        mn    = mwba_pkg::width_mask(n8);
        mm    = mwba_pkg::width_mask(m8);
        ml    = mwba_pkg::width_mask(len8);
        n_bad = n8 > lim;
        m_bad = m8 > lim;

        unique case (action) inside
            mwba_pkg::OP_EXT_SL, mwba_pkg::OP_SETW, mwba_pkg::OP_SEXT:
            begin
                bad  = n_bad | m_bad;
                mask = mm;
            end
            mwba_pkg::OP_EXT_HL:
            begin
                bad  = n_bad | (hi8 < amt8) | (len8 > lim);
                mask = ml;
            end
            mwba_pkg::OP_APPEND:
            begin
                bad  = (n8 + m8) > lim;
                mask = '1;
            end
            mwba_pkg::OP_USHR:
            begin
                bad  = n_bad;
                mask = '1;
            end
            default:
            begin
                bad  = n_bad;
                mask = mn;
            end
        endcase

        data_next.op  = action;
        data_next.a   = value_a & mn;
        data_next.b   = (action == mwba_pkg::OP_APPEND) ? (value_b & mm) : (value_b & mn);
        data_next.shift = (action == mwba_pkg::OP_APPEND) ? width_m : amount;
        // sign bit of an n-bit value; zero for n of zero or the full word
        if (width_n != 7'd0 && n8 < 8'(mwba_pkg::DATA_W))
        begin
            data_next.sext_bit = mwba_pkg::word_t'(1) << width_n[5:0] - 6'd1;
        end
        else
        begin
            data_next.sext_bit = '0;
        end
        // a flagged item gets an empty mask, so its result comes out zero
        data_next.res_mask = bad ? '0 : mask;
        data_next.bad      = bad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[rtl/core/mwba_execute.sv]
module mwba_execute (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  mwba_pkg::dec_t in_data,
    output logic           out_valid,
    output mwba_pkg::exe_t out_data
);

    logic            valid_reg;
    mwba_pkg::exe_t  data_reg;
    mwba_pkg::exe_t  data_next;

    mwba_pkg::word_t a;
    mwba_pkg::word_t b;
    mwba_pkg::word_t shl;
    mwba_pkg::word_t shr;
    mwba_pkg::word_t sext;
    logic [mwba_pkg::HALF_W-1:0] a_lo;
    logic [mwba_pkg::HALF_W-1:0] a_hi;
    logic [mwba_pkg::HALF_W-1:0] b_lo;
    logic [mwba_pkg::HALF_W-1:0] b_hi;

    always_comb
    begin
        a    = in_data.a;
        b    = in_data.b;
        a_lo = a[mwba_pkg::HALF_W-1:0];
        a_hi = a[mwba_pkg::DATA_W-1:mwba_pkg::HALF_W];
        b_lo = b[mwba_pkg::HALF_W-1:0];
        b_hi = b[mwba_pkg::DATA_W-1:mwba_pkg::HALF_W];
        // shifts of 64 or more clear the word
        shl  = in_data.shift[6] ? '0 : (a << in_data.shift[5:0]);
        shr  = in_data.shift[6] ? '0 : (a >> in_data.shift[5:0]);
        sext = (a ^ in_data.sext_bit) - in_data.sext_bit;

        case (in_data.op)
            mwba_pkg::OP_TRUNC:   data_next.pre = a;
            mwba_pkg::OP_ADD:     data_next.pre = a + b;
            mwba_pkg::OP_SUB:     data_next.pre = a - b;
            mwba_pkg::OP_NOT:     data_next.pre = ~a;
            mwba_pkg::OP_AND:     data_next.pre = a & b;
            mwba_pkg::OP_OR:      data_next.pre = a | b;
            mwba_pkg::OP_XOR:     data_next.pre = a ^ b;
            mwba_pkg::OP_SHL:     data_next.pre = shl;
            mwba_pkg::OP_USHR:    data_next.pre = shr;
            mwba_pkg::OP_EXT_SL:  data_next.pre = shr;
            mwba_pkg::OP_EXT_HL:  data_next.pre = shr;
            mwba_pkg::OP_APPEND:  data_next.pre = shl | b;
            mwba_pkg::OP_SETW:    data_next.pre = a;
            mwba_pkg::OP_SEXT:    data_next.pre = sext;
            mwba_pkg::OP_ALLONES: data_next.pre = '1;
            default:              data_next.pre = '0;
        endcase

        // low 64 bits of the product from three 32x32 partial products
        data_next.op       = in_data.op;
        data_next.pp_low   = mwba_pkg::word_t'(a_lo) * mwba_pkg::word_t'(b_lo);
        data_next.pp_mid_a = a_lo * b_hi;
        data_next.pp_mid_b = a_hi * b_lo;
        data_next.res_mask = in_data.res_mask;
        data_next.bad      = in_data.bad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[rtl/core/mwba_merge.sv]
module mwba_merge (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  mwba_pkg::exe_t in_data,
    output logic           out_valid,
    output mwba_pkg::res_t out_data
);

    logic                        valid_reg;
    mwba_pkg::res_t              data_reg;
    mwba_pkg::res_t              data_next;
    logic [mwba_pkg::HALF_W-1:0] mid;
    mwba_pkg::word_t             prod;
    mwba_pkg::word_t             val;

    always_comb
    begin
        mid  = in_data.pp_mid_a + in_data.pp_mid_b;
        prod = in_data.pp_low + {mid, {mwba_pkg::HALF_W{1'b0}}};
        val  = (in_data.op == mwba_pkg::OP_MUL) ? prod : in_data.pre;
        data_next.result       = val & in_data.res_mask;
        data_next.out_of_range = in_data.bad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[rtl/core/masked_width_bitvector_alu.sv]
// Three-stage pipelined bit-vector ALU for widths up to 64 bits, with no state. It takes one
// item per cycle while its output is taken and returns results in order; stage one cuts
// the operands and builds the result mask and range flag, stage two runs the adder, shifter
// and the three 32x32 partial products of the multiplier, stage three sums the partial
// products and applies the mask, and its register holds the result. A full pipeline whose
// output is not taken stops accepting, empty stages ahead of a stall still fill.
module masked_width_bitvector_alu #(
    parameter int unsigned MAX_WIDTH = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    mwba_in_if.sink   req,
    mwba_out_if.source rsp
);

    logic           en1;
    logic           en2;
    logic           en3;
    logic           v1;
    logic           v2;
    logic           v3;
    mwba_pkg::dec_t d1;
    mwba_pkg::exe_t d2;
    mwba_pkg::res_t d3;

    // a stage moves when the one after it is free or moving
    assign en3       = !v3 || rsp.ready;
    assign en2       = !v2 || en3;
    assign en1       = !v1 || en2;
    assign req.ready = en1;

    mwba_decode #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en1),
        .in_valid   (req.valid),
        .action     (req.action),
        .value_a    (req.value_a),
        .value_b    (req.value_b),
        .width_n    (req.width_n),
        .width_m    (req.width_m),
        .amount     (req.amount),
        .high_index (req.high_index),
        .out_valid  (v1),
        .out_data   (d1)
    );

    mwba_execute u_execute (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en2),
        .in_valid  (v1),
        .in_data   (d1),
        .out_valid (v2),
        .out_data  (d2)
    );

    mwba_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en3),
        .in_valid  (v2),
        .in_data   (d2),
        .out_valid (v3),
        .out_data  (d3)
    );

    assign rsp.valid        = v3;
    assign rsp.result       = d3.result;
    assign rsp.out_of_range = d3.out_of_range;

    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        v3 && d3.out_of_range |-> d3.result == '0)
        else $error("flagged result is not zero");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> v1)
        else $error("transfer in lost at decode");

    a_move_exe: assert property (@(posedge clk) disable iff (!rst_n)
        v1 && en2 |=> v2)
        else $error("item lost between decode and execute");

    a_move_out: assert property (@(posedge clk) disable iff (!rst_n)
        v2 && en3 |=> v3)
        else $error("item lost between execute and output");

endmodule

[tb/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_W       = 64;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PIPE_DEPTH  = 3;

    typedef struct {
        mwba_pkg::op_t   action;
        mwba_pkg::word_t a;
        mwba_pkg::word_t b;
        mwba_pkg::cnt_t  n;
        mwba_pkg::cnt_t  m;
        mwba_pkg::cnt_t  amt;
        mwba_pkg::cnt_t  hi;
    } alu_item_t;

    typedef struct {
        mwba_pkg::res_t res;
        mwba_pkg::op_t  action;
        int unsigned    seq;
    } pending_t;

    logic clk;
    logic rst_n;

    mwba_in_if  req_if ();
    mwba_out_if rsp_if ();

    masked_width_bitvector_alu #(
        .MAX_WIDTH (MAX_W)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    pending_t    expected_results[$];
    int unsigned cycle_count;
    int unsigned mismatch_count;
    int unsigned seq_in;
    bit          sender_gaps;
    bit          receiver_stalls;
    int unsigned hold_request;
    int unsigned hold_left;
    int unsigned stall_left;

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("error: %s", msg);
        mismatch_count++;
    endtask

    function automatic mwba_pkg::word_t field_mask(input int unsigned w);
        mwba_pkg::word_t mk;
        if (w >= mwba_pkg::DATA_W)
        begin
            mk = '1;
        end
        else
        begin
            mk = (mwba_pkg::word_t'(1) << w) - mwba_pkg::word_t'(1);
        end
        return mk;
    endfunction

    function automatic mwba_pkg::res_t predict_alu_result(input alu_item_t it);
        int unsigned     n;
        int unsigned     m;
        int unsigned     amt;
        int unsigned     hi;
        mwba_pkg::word_t mn;
        mwba_pkg::word_t an;
        mwba_pkg::word_t bn;
        mwba_pkg::word_t down;
        mwba_pkg::word_t sb;
        mwba_pkg::word_t r;
        logic            bad;
        mwba_pkg::res_t  o;
        n    = 32'(it.n);
        m    = 32'(it.m);
        amt  = 32'(it.amt);
        hi   = 32'(it.hi);
        mn   = field_mask(n);
        an   = it.a & mn;
        bn   = it.b & mn;
        down = (amt >= mwba_pkg::DATA_W) ? '0 : (an >> amt);
        r    = '0;
        bad  = 1'b0;
        case (it.action)
            mwba_pkg::OP_TRUNC:  r = an;
            mwba_pkg::OP_ADD:    r = (an + bn) & mn;
            mwba_pkg::OP_SUB:    r = (an - bn) & mn;
            mwba_pkg::OP_MUL:    r = (an * bn) & mn;
            mwba_pkg::OP_NOT:    r = ~an & mn;
            mwba_pkg::OP_AND:    r = an & bn;
            mwba_pkg::OP_OR:     r = an | bn;
            mwba_pkg::OP_XOR:    r = an ^ bn;
            mwba_pkg::OP_SHL:    r = (amt >= mwba_pkg::DATA_W) ? '0 : ((an << amt) & mn);
            mwba_pkg::OP_USHR:   r = down;
            mwba_pkg::OP_EXT_SL:
            begin
                bad = (m > MAX_W);
                r   = down & field_mask(m);
            end
            mwba_pkg::OP_EXT_HL:
            begin
                if (hi < amt || hi - amt + 1 > MAX_W)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    r = down & field_mask(hi - amt + 1);
                end
            end
            mwba_pkg::OP_APPEND:
            begin
                if (n + m > MAX_W)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    r = ((m >= mwba_pkg::DATA_W) ? '0 : (an << m)) | (it.b & field_mask(m));
                end
            end
            mwba_pkg::OP_SETW:
            begin
                bad = (m > MAX_W);
                r   = an & field_mask(m);
            end
            mwba_pkg::OP_SEXT:
            begin
                bad = (m > MAX_W);
                if (n == 0)
                begin
                    r = '0;
                end
                else if (n >= mwba_pkg::DATA_W)
                begin
                    r = an & field_mask(m);
                end
                else
                begin
                    // flip and subtract the sign bit to extend it
                    sb = mwba_pkg::word_t'(1) << (n - 1);
                    r  = ((an ^ sb) - sb) & field_mask(m);
                end
            end
            mwba_pkg::OP_ALLONES: r = mn;
            default:              r = '0;
        endcase
        if (n > MAX_W && it.action != mwba_pkg::OP_APPEND)
        begin
            bad = 1'b1;
        end
        if (bad)
        begin
            r = '0;
        end
        o.result       = r;
        o.out_of_range = bad;
        return o;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        int unsigned g;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            g = 0;
        end
        else if (r < 90)
        begin
            g = $urandom_range(1, 3);
        end
        else
        begin
            g = $urandom_range(8, 40);
        end
        return g;
    endfunction

    // receiver: random stalls plus a long hold-off on request
    initial
    begin
        rsp_if.ready = 1'b0;
        hold_left    = 0;
        stall_left   = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                rsp_if.ready = 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                rsp_if.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_if.ready = 1'b1;
                if (receiver_stalls)
                begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // result checker, one transfer per rising edge at most
    always @(posedge clk)
    begin
        pending_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %h flag %b",
                                          rsp_if.result, rsp_if.out_of_range));
            end
            else
            begin
                want = expected_results.pop_front();
                if (rsp_if.result !== want.res.result)
                begin
                    report_mismatch($sformatf("item %0d op %0d: result %h, want %h",
                                              want.seq, want.action, rsp_if.result,
                                              want.res.result));
                end
                if (rsp_if.out_of_range !== want.res.out_of_range)
                begin
                    report_mismatch($sformatf("item %0d op %0d: out_of_range %b, want %b",
                                              want.seq, want.action, rsp_if.out_of_range,
                                              want.res.out_of_range));
                end
            end
        end
    end

    task automatic send_item(input alu_item_t it);
        int unsigned gap;
        pending_t    p;
        gap = sender_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            req_if.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_if.action     = it.action;
        req_if.value_a    = it.a;
        req_if.value_b    = it.b;
        req_if.width_n    = it.n;
        req_if.width_m    = it.m;
        req_if.amount     = it.amt;
        req_if.high_index = it.hi;
        req_if.valid      = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!req_if.ready);
        p.res    = predict_alu_result(it);
        p.action = it.action;
        p.seq    = seq_in;
        seq_in++;
        expected_results.push_back(p);
    endtask

    task automatic send_op(input mwba_pkg::op_t action, input mwba_pkg::word_t a,
                           input mwba_pkg::word_t b,
                           input int unsigned n, input int unsigned m,
                           input int unsigned amt, input int unsigned hi);
        alu_item_t it;
        it.action = action;
        it.a      = a;
        it.b      = b;
        it.n      = mwba_pkg::cnt_t'(n);
        it.m      = mwba_pkg::cnt_t'(m);
        it.amt    = mwba_pkg::cnt_t'(amt);
        it.hi     = mwba_pkg::cnt_t'(hi);
        send_item(it);
    endtask

    task automatic drain_results();
        @(negedge clk);
        req_if.valid = 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic mwba_pkg::word_t random_word();
        mwba_pkg::word_t w;
        case ($urandom_range(0, 9))
            0:       w = '0;
            1:       w = '1;
            2:       w = mwba_pkg::word_t'(1) << $urandom_range(0, 63);
            3:       w = ~(mwba_pkg::word_t'(1) << $urandom_range(0, 63));
            default: w = {$urandom(), $urandom()};
        endcase
        return w;
    endfunction

    function automatic int unsigned random_width();
        int unsigned r;
        int unsigned w;
        r = $urandom_range(0, 19);
        if (r == 0)
        begin
            w = $urandom_range(MAX_W + 1, 127);
        end
        else if (r == 1)
        begin
            w = MAX_W;
        end
        else if (r == 2)
        begin
            w = 0;
        end
        else
        begin
            w = $urandom_range(1, MAX_W);
        end
        return w;
    endfunction

    function automatic alu_item_t random_item();
        alu_item_t   it;
        int unsigned n;
        int unsigned m;
        int unsigned amt;
        int unsigned hi;
        int unsigned r;
        it.action = mwba_pkg::op_t'($urandom_range(mwba_pkg::OP_TRUNC,
                                                   mwba_pkg::OP_ALLONES));
        it.a      = random_word();
        it.b      = random_word();
        n         = random_width();
        m         = random_width();
        r         = $urandom_range(0, 19);
        if (r < 17)
        begin
            amt = $urandom_range(0, 63);
        end
        else if (r == 17)
        begin
            amt = 64;
        end
        else
        begin
            amt = $urandom_range(65, 127);
        end
        hi = $urandom_range(0, 127);
        // mostly well-formed append and hi/lo extract so the datapath is reached
        if (it.action == mwba_pkg::OP_APPEND && n <= MAX_W && $urandom_range(0, 9) != 0)
        begin
            m = $urandom_range(0, MAX_W - n);
        end
        if (it.action == mwba_pkg::OP_EXT_HL && $urandom_range(0, 4) != 0)
        begin
            hi = amt + $urandom_range(0, 63);
            if (hi > 127)
            begin
                hi = 127;
            end
        end
        it.n   = mwba_pkg::cnt_t'(n);
        it.m   = mwba_pkg::cnt_t'(m);
        it.amt = mwba_pkg::cnt_t'(amt);
        it.hi  = mwba_pkg::cnt_t'(hi);
        return it;
    endfunction

    task automatic test_directed_corners();
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        send_op(mwba_pkg::OP_TRUNC,   '1, '0, 64, 0, 0, 0);
        send_op(mwba_pkg::OP_TRUNC,   '1, '1, 0, 0, 0, 0);
        send_op(mwba_pkg::OP_ADD,     '1, 64'd1, 64, 0, 0, 0);
        send_op(mwba_pkg::OP_SUB,     '0, 64'd1, 37, 0, 0, 0);
        send_op(mwba_pkg::OP_MUL,     '1, '1, 64, 0, 0, 0);
        send_op(mwba_pkg::OP_MUL,     64'h0000_0001_ffff_ffff, 64'hffff_ffff_0000_0003,
                63, 0, 0, 0);
        send_op(mwba_pkg::OP_NOT,     '0, '0, 127, 0, 0, 0);
        send_op(mwba_pkg::OP_AND,     '1, 64'h5555_aaaa_5555_aaaa, 64, 0, 0, 0);
        send_op(mwba_pkg::OP_OR,      64'h8000_0000_0000_0000, '0, 1, 0, 0, 0);
        send_op(mwba_pkg::OP_XOR,     '1, 64'h0123_4567_89ab_cdef, 64, 127, 127, 127);
        send_op(mwba_pkg::OP_SHL,     '1, '0, 64, 0, 64, 0);
        send_op(mwba_pkg::OP_SHL,     '1, '0, 64, 0, 63, 0);
        send_op(mwba_pkg::OP_USHR,    '1, '0, 64, 0, 63, 0);
        send_op(mwba_pkg::OP_EXT_SL,  '1, '0, 64, 8, 64, 0);
        send_op(mwba_pkg::OP_EXT_SL,  '1, '0, 64, 65, 4, 0);
        send_op(mwba_pkg::OP_EXT_HL,  '1, '0, 64, 0, 10, 9);
        send_op(mwba_pkg::OP_EXT_HL,  64'hfedc_ba98_7654_3210, '0, 64, 0, 0, 63);
        send_op(mwba_pkg::OP_EXT_HL,  '1, '0, 64, 0, 0, 127);
        send_op(mwba_pkg::OP_APPEND,  64'hdead_beef, 64'hcafe_f00d, 32, 32, 0, 0);
        send_op(mwba_pkg::OP_APPEND,  '1, '1, 40, 25, 0, 0);
        send_op(mwba_pkg::OP_APPEND,  '1, '1, 0, 64, 0, 0);
        send_op(mwba_pkg::OP_SETW,    '1, '0, 64, 127, 0, 0);
        send_op(mwba_pkg::OP_SEXT,    '1, '0, 0, 64, 0, 0);
        send_op(mwba_pkg::OP_SEXT,    64'h80, '0, 8, 16, 0, 0);
        send_op(mwba_pkg::OP_ALLONES, '0, '0, 127, 0, 0, 0);
        drain_results();
    endtask

    task automatic test_back_to_back();
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        repeat (50) send_item(random_item());
        send_op(mwba_pkg::OP_SEXT,    64'h1, '0, 1, 64, 0, 0);
        send_op(mwba_pkg::OP_SEXT,    '1, '0, 64, 64, 0, 0);
        send_op(mwba_pkg::OP_ALLONES, '0, '0, 64, 0, 0, 0);
        drain_results();
    endtask

    task automatic test_output_hold_off();
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        hold_request    = 300;
        // sender keeps offering while the output is held, so the pipeline backs up
        repeat (30) send_item(random_item());
        drain_results();
    endtask

    task automatic test_random_mix();
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        repeat (450) send_item(random_item());
        drain_results();
    endtask

    initial
    begin
        rst_n              = 1'b0;
        req_if.valid       = 1'b0;
        req_if.action      = mwba_pkg::OP_TRUNC;
        req_if.value_a     = '0;
        req_if.value_b     = '0;
        req_if.width_n     = '0;
        req_if.width_m     = '0;
        req_if.amount      = '0;
        req_if.high_index  = '0;
        cycle_count        = 0;
        mismatch_count     = 0;
        seq_in             = 0;
        sender_gaps        = 1'b0;
        receiver_stalls    = 1'b0;
        hold_request       = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_corners();
        test_back_to_back();
        test_output_hold_off();
        test_random_mix();

        // let any stray transfer show up before the verdict
        repeat (PIPE_DEPTH + 5) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
